>>> rtl/pip_test_pkg.sv
// ----------------------------------------------------------------------------
// Point-in-polygon test package
// Register indexes and fixed widths shared by the point-in-polygon test unit.
// ----------------------------------------------------------------------------
package pip_test_pkg;

    // query point registers are signed fixed point of this width
    localparam int PT_BITS = 24;

    // configuration register index
    localparam int REG_IDX_BITS = 1;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_POINT_X = 1'b0,
        REG_POINT_Y = 1'b1
    } reg_index_t;

    // edge lanes: the edge from the previous vertex and the closing edge
    localparam int NUM_EDGES = 2;
    localparam int EDGE_PREV = 0;
    localparam int EDGE_CLOSE = 1;

endpackage

>>> rtl/point_in_polygon_test_unit.sv
// ----------------------------------------------------------------------------
// Point-in-polygon test unit
// Crossing-number test of a configured query point against a streamed polygon.
// ----------------------------------------------------------------------------
// Vertices arrive one word per cycle on the s_ channel, x and y as signed
// integers, with s_tlast set on the final vertex of a polygon. The query point
// is written beforehand through the cfg_ port as signed fixed point with
// FRAC_BITS fraction bits (index 0 = x, index 1 = y). Each word tests the edge
// from the previous vertex, and the final word also tests the closing edge
// back to the first vertex; one result word per polygon carries a single
// inside bit, set when the left and right crossing parities are both odd. The
// unit takes one vertex every cycle unless stalled; the result of a polygon
// is registered through the three pipeline stages (input register,
// registered cross products, parity update into the output register), which
// advance together and hold only while a result waits on m_tready.
module point_in_polygon_test_unit #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic aclk,
    input  logic aresetn,

    // configuration write port
    input  logic                                    cfg_we,
    input  logic [pip_test_pkg::REG_IDX_BITS-1:0]   cfg_index,
    input  logic [pip_test_pkg::PT_BITS-1:0]        cfg_wdata,

    // vertex stream
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    // fields from bit 0: vertex_x, vertex_y, zero fill
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]       s_tdata,
    input  logic                                    s_tlast,   // last_vertex

    // result stream
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    // fields from bit 0: inside_res, zero fill
    output logic [7:0]                              m_tdata
);
    import pip_test_pkg::*;

    // working widths: scaled coordinates, differences and products
    localparam int SC_BITS = COORD_BITS + FRAC_BITS;
    localparam int DW = ((SC_BITS > PT_BITS) ? SC_BITS : PT_BITS) + 1;
    localparam int DYW = COORD_BITS + 1;
    localparam int PW = DW + DYW;

    // pipeline advance: everything moves unless a result is stuck
    logic pipe_en;
    assign pipe_en  = !m_tvalid || m_tready;
    assign s_tready = pipe_en;

    logic in_acc;
    assign in_acc = s_tvalid && pipe_en;

    // query point registers
    logic signed [PT_BITS-1:0] point_x_reg;
    logic signed [PT_BITS-1:0] point_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            point_x_reg <= '0;
            point_y_reg <= '0;
        end else if (cfg_we) begin
            case (reg_index_t'(cfg_index))
                REG_POINT_X: point_x_reg <= cfg_wdata;
                REG_POINT_Y: point_y_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // incoming vertex
    logic signed [COORD_BITS-1:0] vx;
    logic signed [COORD_BITS-1:0] vy;
    assign vx = s_tdata[COORD_BITS-1:0];
    assign vy = s_tdata[2*COORD_BITS-1:COORD_BITS];

    // polygon walk state
    logic                         mid_polygon_reg;
    logic signed [COORD_BITS-1:0] prev_x_reg;
    logic signed [COORD_BITS-1:0] prev_y_reg;
    logic signed [COORD_BITS-1:0] first_x_reg;
    logic signed [COORD_BITS-1:0] first_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_polygon_reg <= 1'b0;
            prev_x_reg      <= '0;
            prev_y_reg      <= '0;
            first_x_reg     <= '0;
            first_y_reg     <= '0;
        end else if (in_acc) begin
            prev_x_reg <= vx;
            prev_y_reg <= vy;
            if (!mid_polygon_reg) begin
                first_x_reg <= vx;
                first_y_reg <= vy;
            end
            mid_polygon_reg <= !s_tlast;
        end
    end

    // stage 1: edge endpoints for both lanes
    logic                         s1_valid_reg;
    logic                         s1_last_reg;
    logic                         s1_en_reg [NUM_EDGES];
    logic signed [COORD_BITS-1:0] s1_x1_reg [NUM_EDGES];
    logic signed [COORD_BITS-1:0] s1_y1_reg [NUM_EDGES];
    logic signed [COORD_BITS-1:0] s1_x2_reg [NUM_EDGES];
    logic signed [COORD_BITS-1:0] s1_y2_reg [NUM_EDGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s1_last_reg           <= s_tlast;
            // edge from the previous vertex, only once a polygon is open
            s1_en_reg[EDGE_PREV]  <= mid_polygon_reg;
            s1_x1_reg[EDGE_PREV]  <= prev_x_reg;
            s1_y1_reg[EDGE_PREV]  <= prev_y_reg;
            s1_x2_reg[EDGE_PREV]  <= vx;
            s1_y2_reg[EDGE_PREV]  <= vy;
            // closing edge back to the first vertex
            s1_en_reg[EDGE_CLOSE] <= s_tlast;
            s1_x1_reg[EDGE_CLOSE] <= vx;
            s1_y1_reg[EDGE_CLOSE] <= vy;
            s1_x2_reg[EDGE_CLOSE] <= mid_polygon_reg ? first_x_reg : vx;
            s1_y2_reg[EDGE_CLOSE] <= mid_polygon_reg ? first_y_reg : vy;
        end
    end

    // per-lane span test and cross products
    logic                 span_c [NUM_EDGES];
    logic                 up_c   [NUM_EDGES];
    logic signed [PW-1:0] l1_c   [NUM_EDGES];
    logic signed [PW-1:0] l2_c   [NUM_EDGES];

    logic signed [DW-1:0] px_w;
    logic signed [DW-1:0] py_w;
    assign px_w = DW'(point_x_reg);
    assign py_w = DW'(point_y_reg);

    for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge
        logic signed [DW-1:0]  x1_s;
        logic signed [DW-1:0]  y1_s;
        logic signed [DW-1:0]  y2_s;
        logic signed [DW-1:0]  dx_pt;
        logic signed [DW-1:0]  dy_pt;
        logic signed [DYW-1:0] dx_e;
        logic signed [DYW-1:0] dy_e;
        logic                  all_above;
        logic                  all_below;

        // vertices scaled to the point's fixed-point format
        assign x1_s = DW'(s1_x1_reg[e]) <<< FRAC_BITS;
        assign y1_s = DW'(s1_y1_reg[e]) <<< FRAC_BITS;
        assign y2_s = DW'(s1_y2_reg[e]) <<< FRAC_BITS;

        // half-open span on y, horizontal edges never cross
        assign all_above = (y1_s > py_w) && (y2_s > py_w);
        assign all_below = (y1_s <= py_w) && (y2_s <= py_w);
        assign span_c[e] = s1_en_reg[e] && !all_above && !all_below;
        assign up_c[e]   = s1_y2_reg[e] > s1_y1_reg[e];

        assign dx_pt = px_w - x1_s;
        assign dy_pt = py_w - y1_s;
        assign dx_e  = DYW'(s1_x2_reg[e]) - DYW'(s1_x1_reg[e]);
        assign dy_e  = DYW'(s1_y2_reg[e]) - DYW'(s1_y1_reg[e]);

        assign l1_c[e] = PW'(dx_pt) * PW'(dy_e);
        assign l2_c[e] = PW'(dy_pt) * PW'(dx_e);
    end

    // stage 2: registered products and edge flags
    logic                 s2_valid_reg;
    logic                 s2_last_reg;
    logic                 s2_span_reg [NUM_EDGES];
    logic                 s2_up_reg   [NUM_EDGES];
    logic signed [PW-1:0] s2_l1_reg   [NUM_EDGES];
    logic signed [PW-1:0] s2_l2_reg   [NUM_EDGES];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s2_last_reg <= s1_last_reg;
            for (int e = 0; e < NUM_EDGES; e++) begin
                s2_span_reg[e] <= span_c[e];
                s2_up_reg[e]   <= up_c[e];
                s2_l1_reg[e]   <= l1_c[e];
                s2_l2_reg[e]   <= l2_c[e];
            end
        end
    end

    // stage 3: side of each crossing and parity update, previous edge first
    logic left_parity_reg;
    logic right_parity_reg;
    logic left_next;
    logic right_next;
    logic m_tvalid_reg;
    logic inside_res_reg;

    always_comb begin
        logic right_side;
        left_next  = left_parity_reg;
        right_next = right_parity_reg;
        for (int e = 0; e < NUM_EDGES; e++) begin
            right_side = s2_up_reg[e] ^ (s2_l1_reg[e] < s2_l2_reg[e]);
            if (s2_span_reg[e]) begin
                if (right_side) begin
                    right_next = !right_next;
                end else begin
                    left_next = !left_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_parity_reg  <= 1'b0;
            right_parity_reg <= 1'b0;
            m_tvalid_reg     <= 1'b0;
        end else if (pipe_en) begin
            m_tvalid_reg <= s2_valid_reg && s2_last_reg;
            if (s2_valid_reg) begin
                // parities restart after each polygon
                left_parity_reg  <= s2_last_reg ? 1'b0 : left_next;
                right_parity_reg <= s2_last_reg ? 1'b0 : right_next;
            end
        end
    end

    // result word
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            inside_res_reg <= left_next && right_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, inside_res_reg};

endmodule

>>> sim/pip_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Point-in-polygon result checker
// Watches the configuration port and both streams of the test unit. It keeps
// its own copy of the query point and of the polygon walk, predicts the inside
// bit of every polygon and compares it with each result word.
// ----------------------------------------------------------------------------
module pip_result_checker #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_we,
    input  logic [pip_test_pkg::REG_IDX_BITS-1:0]   cfg_index,
    input  logic [pip_test_pkg::PT_BITS-1:0]        cfg_wdata,
    input  logic                                    s_tvalid,
    input  logic                                    s_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]       s_tdata,
    input  logic                                    s_tlast,
    input  logic                                    m_tvalid,
    input  logic                                    m_tready,
    input  logic [7:0]                              m_tdata,
    output int                                      mismatches,
    output int                                      pending
);
    import pip_test_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // query point and polygon walk state
    longint query_x;
    longint query_y;
    longint prev_vx;
    longint prev_vy;
    longint start_vx;
    longint start_vy;
    bit     left_odd;
    bit     right_odd;
    bit     in_polygon;

    // inside bits still owed by the unit, oldest first
    bit     inside_due[$];
    int     error_count;

    longint vx;
    longint vy;
    bit     want;
    bit     got;

    // which side of the query point an edge crosses: +1 right, -1 left, 0 none
    function automatic int crossing_side(longint x1, longint y1, longint x2, longint y2);
        longint scale;
        longint lo;
        longint hi;
        longint l1;
        longint l2;
        int     dir;
        scale = longint'(1) << FRAC_BITS;
        lo = ((y1 < y2) ? y1 : y2) * scale;
        hi = ((y1 < y2) ? y2 : y1) * scale;
        // half-open span in y, horizontal edges never cross
        if (lo > query_y || hi <= query_y)
            return 0;
        dir = (y2 > y1) ? 1 : -1;
        l1 = (query_x - x1 * scale) * (y2 - y1);
        l2 = (query_y - y1 * scale) * (x2 - x1);
        return (l1 < l2) ? -dir : dir;
    endfunction

    function automatic void walk_edge(longint x1, longint y1, longint x2, longint y2);
        int side;
        side = crossing_side(x1, y1, x2, y2);
        if (side > 0)
            right_odd = !right_odd;
        else if (side < 0)
            left_odd = !left_odd;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            query_x     = 0;
            query_y     = 0;
            prev_vx     = 0;
            prev_vy     = 0;
            start_vx    = 0;
            start_vy    = 0;
            left_odd    = 1'b0;
            right_odd   = 1'b0;
            in_polygon  = 1'b0;
            error_count = 0;
            inside_due.delete();
        end else begin
            // query point writes
            if (cfg_we) begin
                case (cfg_index)
                    REG_POINT_X: query_x = longint'($signed(cfg_wdata));
                    REG_POINT_Y: query_y = longint'($signed(cfg_wdata));
                    default: ;
                endcase
            end

            // result word against the oldest prediction
            if (m_tvalid && m_tready) begin
                got = m_tdata[0];
                if (inside_due.size() == 0) begin
                    if (error_count < REPORT_LIMIT)
                        $display("%0t: result word with nothing expected, inside=%0b",
                                 $realtime, got);
                    error_count++;
                end else begin
                    want = inside_due.pop_front();
                    if (got !== want) begin
                        if (error_count < REPORT_LIMIT)
                            $display("%0t: inside mismatch, expected %0b, got %0b",
                                     $realtime, want, got);
                        error_count++;
                    end
                end
            end

            // vertex word: walk the edge from the previous vertex
            if (s_tvalid && s_tready) begin
                vx = longint'($signed(s_tdata[COORD_BITS-1:0]));
                vy = longint'($signed(s_tdata[2*COORD_BITS-1:COORD_BITS]));
                if (!in_polygon) begin
                    start_vx   = vx;
                    start_vy   = vy;
                    in_polygon = 1'b1;
                end else begin
                    walk_edge(prev_vx, prev_vy, vx, vy);
                end
                prev_vx = vx;
                prev_vy = vy;
                // closing edge and verdict on the final vertex
                if (s_tlast) begin
                    walk_edge(vx, vy, start_vx, start_vy);
                    inside_due.insert(inside_due.size(), left_odd && right_odd);
                    left_odd   = 1'b0;
                    right_odd  = 1'b0;
                    in_polygon = 1'b0;
                end
            end
        end
        mismatches <= error_count;
        pending    <= inside_due.size();
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Point-in-polygon test unit testbench
// Streams directed and random polygons against a range of query points, with
// random gaps on both streams, and lets the result checker judge every word.
// ----------------------------------------------------------------------------
module testbench;
    import pip_test_pkg::*;

    localparam int COORD_BITS   = 16;
    localparam int FRAC_BITS    = 8;
    localparam int DATA_W       = ((2*COORD_BITS+7)/8)*8;
    localparam int ITEM_TARGET  = 1550;
    localparam int IDLE_PCT     = 29;
    localparam int DRAIN_CYCLES = 8;
    localparam int QUIET_LIMIT  = 4000;
    localparam int PT_MAX       = 8388607;
    localparam int PT_MIN       = -8388608;
    localparam int C_MAX        = 32767;
    localparam int C_MIN        = -32768;

    logic                       aclk      = 1'b0;
    logic                       aresetn   = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [REG_IDX_BITS-1:0]    cfg_index = REG_POINT_X;
    logic [PT_BITS-1:0]         cfg_wdata = '0;
    logic                       s_tvalid  = 1'b0;
    logic                       s_tready;
    logic [DATA_W-1:0]          s_tdata   = '0;   // vertex_x, vertex_y
    logic                       s_tlast   = 1'b0; // last_vertex
    logic                       m_tvalid;
    logic                       m_tready  = 1'b0;
    logic [7:0]                 m_tdata;          // inside_res, zero fill

    int  mismatches;
    int  pending;
    int  quiet_cycles = 0;
    int  vertices_sent = 0;
    bit  calm = 1'b0;

    always #5 aclk = ~aclk;

    point_in_polygon_test_unit #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    pip_result_checker #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_checker (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .mismatches(mismatches),
        .pending   (pending)
    );

    // result side back-pressure
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    // watchdog: cycles without any word moving
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("[FAIL] regression broken");
        $finish;
    end

    // one vertex word, with a random gap ahead of it
    task automatic put_vertex(input int vx, input int vy, input bit last);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {vy[COORD_BITS-1:0], vx[COORD_BITS-1:0]};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        vertices_sent++;
    endtask

    // hold the sender until every result is in and the pipeline is empty
    task automatic settle;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_point(input int px, input int py);
        cfg_we    <= 1'b1;
        cfg_index <= REG_POINT_X;
        cfg_wdata <= px[PT_BITS-1:0];
        @(posedge aclk);
        cfg_index <= REG_POINT_Y;
        cfg_wdata <= py[PT_BITS-1:0];
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    function automatic int clamp_coord(int v);
        return (v > C_MAX) ? C_MAX : ((v < C_MIN) ? C_MIN : v);
    endfunction

    initial begin
        int  phase;
        int  mode;
        int  cx;
        int  cy;
        int  span;
        int  px;
        int  py;
        int  corners;
        int  pick;
        int  vx;
        int  vy;
        bit  wide;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // square around the reset point
        put_vertex(-10, -10, 1'b0);
        put_vertex( 10, -10, 1'b0);
        put_vertex( 10,  10, 1'b0);
        put_vertex(-10,  10, 1'b1);
        // single-vertex polygon
        put_vertex(3, 3, 1'b1);
        // full coordinate range square
        put_vertex(C_MIN, C_MIN, 1'b0);
        put_vertex(C_MAX, C_MIN, 1'b0);
        put_vertex(C_MAX, C_MAX, 1'b0);
        put_vertex(C_MIN, C_MAX, 1'b1);
        // two-vertex polygon through the point
        put_vertex(-5, -5, 1'b0);
        put_vertex( 5,  5, 1'b1);

        // point at the register extremes
        settle();
        set_point(PT_MAX, PT_MIN);
        put_vertex(C_MIN, C_MIN, 1'b0);
        put_vertex(C_MAX, C_MIN, 1'b0);
        put_vertex(C_MAX, C_MAX, 1'b0);
        put_vertex(C_MIN, C_MAX, 1'b1);

        // point sitting on a vertex
        settle();
        set_point(10 << FRAC_BITS, 10 << FRAC_BITS);
        put_vertex( 0,  0, 1'b0);
        put_vertex(10,  0, 1'b0);
        put_vertex(10, 10, 1'b0);
        put_vertex( 0, 10, 1'b1);

        // point moved halfway through a polygon
        put_vertex( 0, 0, 1'b0);
        put_vertex(20, 0, 1'b0);
        settle();
        set_point((5 << FRAC_BITS) + 128, (5 << FRAC_BITS) + 128);
        put_vertex(20, 20, 1'b0);
        put_vertex( 0, 20, 1'b1);

        // random phases, each with its own query point and vertex box
        phase = 0;
        while (vertices_sent < ITEM_TARGET) begin
            phase++;
            settle();
            calm = (phase == 3);
            mode = $urandom_range(0, 5);
            wide = (mode <= 1);
            cx   = 0;
            cy   = 0;
            span = 0;
            if (mode == 0) begin
                px = $urandom_range(1) ? PT_MAX : PT_MIN;
                py = $urandom_range(1) ? PT_MAX : PT_MIN;
            end else if (mode == 1) begin
                px = int'($urandom_range(24'hFFFFFF)) + PT_MIN;
                py = int'($urandom_range(24'hFFFFFF)) + PT_MIN;
            end else begin
                cx   = int'($urandom_range(64000)) - 32000;
                cy   = int'($urandom_range(64000)) - 32000;
                pick = $urandom_range(3);
                span = (pick == 0) ? 2 : (pick == 1) ? 8 : (pick == 2) ? 64 : 1000;
                px   = cx * (1 << FRAC_BITS);
                py   = cy * (1 << FRAC_BITS);
                // half the time off the integer grid
                if ($urandom_range(1)) begin
                    px += $urandom_range(255);
                    py += $urandom_range(255);
                end
            end
            set_point(px, py);

            repeat ($urandom_range(4, 20)) begin
                pick = $urandom_range(99);
                corners = (pick < 10) ? $urandom_range(1, 2) :
                          (pick < 85) ? $urandom_range(3, 8) : $urandom_range(9, 24);
                vx = 0;
                vy = 0;
                for (int k = 0; k < corners; k++) begin
                    pick = $urandom_range(99);
                    // repeated vertex or horizontal edge now and then
                    if (k > 0 && pick < 5) begin
                    end else if (wide) begin
                        vx = int'($urandom_range(16'hFFFF)) + C_MIN;
                        if (!(k > 0 && pick < 20))
                            vy = int'($urandom_range(16'hFFFF)) + C_MIN;
                    end else begin
                        vx = clamp_coord(cx + int'($urandom_range(2 * span)) - span);
                        if (!(k > 0 && pick < 20))
                            vy = clamp_coord(cy + int'($urandom_range(2 * span)) - span);
                    end
                    put_vertex(vx, vy, k == corners - 1);
                end
            end
        end

        settle();
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> filelist.f
rtl/pip_test_pkg.sv
rtl/point_in_polygon_test_unit.sv
sim/pip_result_checker.sv
sim/testbench.sv
